[sv/bafe_pkg.sv]
// Shared types and codes for the advertising data field extractor.
`default_nettype none

package bafe_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned KIND_W  = 3;
    localparam int unsigned VALUE_W = 64;
    localparam int unsigned PHASE_W = 2;

    localparam logic [BYTE_W-1:0] LIMIT_RESET = 8'd31;

    localparam logic [PHASE_W-1:0] PH_IDLE = 2'd0;
    localparam logic [PHASE_W-1:0] PH_LEN  = 2'd1;
    localparam logic [PHASE_W-1:0] PH_TYPE = 2'd2;
    localparam logic [PHASE_W-1:0] PH_DATA = 2'd3;

    localparam logic [BYTE_W-1:0] AD_FLAGS = 8'h01;
    localparam logic [BYTE_W-1:0] AD_U16   = 8'h02;
    localparam logic [BYTE_W-1:0] AD_U128  = 8'h06;
    localparam logic [BYTE_W-1:0] AD_NAME  = 8'h09;
    localparam logic [BYTE_W-1:0] AD_TXPWR = 8'h0A;
    localparam logic [BYTE_W-1:0] AD_APPR  = 8'h19;
    localparam logic [BYTE_W-1:0] AD_MANUF = 8'hFF;

    localparam logic [KIND_W-1:0] KIND_NAME  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_TXPWR = 3'd1;
    localparam logic [KIND_W-1:0] KIND_APPR  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_U16   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_U128  = 3'd4;
    localparam logic [KIND_W-1:0] KIND_FLAGS = 3'd5;
    localparam logic [KIND_W-1:0] KIND_MANUF = 3'd6;
    localparam logic [KIND_W-1:0] KIND_END   = 3'd7;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [VALUE_W-1:0] value;
        logic               half;
        logic               done;
    } t_result;

endpackage

`default_nettype wire

[sv/bafe_ifs.sv]
// Handshake channel interfaces: payload bytes in, fields out, limit register write.
`default_nettype none

interface bafe_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ad_byte;
    logic       first_byte;
    modport source (output valid, ad_byte, first_byte, input ready);
    modport sink   (input valid, ad_byte, first_byte, output ready);
endinterface

interface bafe_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  field_kind;
    logic [63:0] field_value;
    logic        half_index;
    logic        payload_done;
    modport source (output valid, field_kind, field_value, half_index, payload_done,
                    input ready);
    modport sink   (input valid, field_kind, field_value, half_index, payload_done,
                    output ready);
endinterface

interface bafe_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_limit;
    modport source (output valid, payload_limit, input ready);
    modport sink   (input valid, payload_limit, output ready);
endinterface

`default_nettype wire

[sv/ble_adv_field_extractor.sv]
// Top level of the advertising data field extractor.
// Takes one advertising payload byte per word and walks its length/type/data records,
// sending name bytes, TX power, appearance, flags, the first two manufacturer bytes and
// the first 16-bit or 128-bit UUID as result words; the byte that ends a payload (zero
// length or payload_limit bytes) carries payload_done, or sends an end-only word. One
// byte is accepted every cycle unless the output stalls; a byte passes an input
// register and the parse logic, and its result word is then held in the output
// register. The output register decouples the sides, so input stalls only when a
// result word is held and not taken.
// The limit register may be written only while no byte is in flight.
`default_nettype none

module ble_adv_field_extractor (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    bafe_in_if.sink      i_byte,
    bafe_out_if.source   o_field,
    bafe_cfg_if.sink     i_cfg
);

    logic [7:0]        r_limit;
    logic              res_valid;
    logic              res_ready;
    bafe_pkg::t_result res;
    bafe_pkg::t_result out_res;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= bafe_pkg::LIMIT_RESET;
        end else if (i_cfg.valid) begin
            r_limit <= i_cfg.payload_limit;
        end
    end

    bafe_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_limit      (r_limit),
        .i_valid      (i_byte.valid),
        .o_ready      (i_byte.ready),
        .i_ad_byte    (i_byte.ad_byte),
        .i_first_byte (i_byte.first_byte),
        .o_res_valid  (res_valid),
        .o_res        (res),
        .i_res_ready  (res_ready)
    );

    bafe_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (res_valid),
        .o_ready (res_ready),
        .i_res   (res),
        .o_valid (o_field.valid),
        .i_ready (o_field.ready),
        .o_res   (out_res)
    );

    assign o_field.field_kind   = out_res.kind;
    assign o_field.field_value  = out_res.value;
    assign o_field.half_index   = out_res.half;
    assign o_field.payload_done = out_res.done;

endmodule

`default_nettype wire

[sv/bafe_core.sv]
// Input register, record parser state and per-byte field extraction.
`default_nettype none

module bafe_core (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic [7:0]           i_limit,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic [7:0]           i_ad_byte,
    input  wire logic                 i_first_byte,
    output logic                      o_res_valid,
    output bafe_pkg::t_result         o_res,
    input  wire logic                 i_res_ready
);

    logic                            r_in_valid;
    logic [7:0]                      r_ad_byte;
    logic                            r_first;

    logic [bafe_pkg::PHASE_W-1:0]    r_phase, n_phase, c_phase;
    logic [7:0]                      r_left, n_left, c_left;
    logic [7:0]                      r_type, n_type, c_type;
    logic [7:0]                      r_idx, n_idx, c_idx;
    logic [63:0]                     r_acc, n_acc, c_acc;
    logic [7:0]                      r_cnt, n_cnt, c_cnt;

    logic                            active;
    logic                            emit;
    logic                            done;
    logic                            advance;
    logic [2:0]                      pos;
    logic [63:0]                     acc_new;
    logic [7:0]                      left_dec;
    bafe_pkg::t_result               res;

    always_comb begin
        c_phase = r_phase;
        c_left  = r_left;
        c_type  = r_type;
        c_idx   = r_idx;
        c_acc   = r_acc;
        c_cnt   = r_cnt;
        if (r_first) begin
            c_phase = bafe_pkg::PH_LEN;
            c_left  = '0;
            c_type  = '0;
            c_idx   = '0;
            c_acc   = '0;
            c_cnt   = '0;
        end
        active = r_first || (r_phase != bafe_pkg::PH_IDLE);

        n_phase = c_phase;
        n_left  = c_left;
        n_type  = c_type;
        n_idx   = c_idx;
        n_acc   = c_acc;
        n_cnt   = (c_cnt == 8'hFF) ? c_cnt : c_cnt + 8'd1;

        emit       = 1'b0;
        done       = 1'b0;
        res.kind   = bafe_pkg::KIND_END;
        res.value  = '0;
        res.half   = 1'b0;

        pos      = c_idx[2:0];
        acc_new  = ((pos == 3'd0) ? 64'd0 : c_acc)
                 | ({56'd0, r_ad_byte} << {pos, 3'b000});
        left_dec = c_left - 8'd1;

        unique case (c_phase)
            bafe_pkg::PH_IDLE: begin
            end
            bafe_pkg::PH_LEN: begin
                if (r_ad_byte == 8'd0) begin
                    done = 1'b1;
                end else begin
                    n_left  = r_ad_byte;
                    n_phase = bafe_pkg::PH_TYPE;
                end
            end
            bafe_pkg::PH_TYPE: begin
                n_type  = r_ad_byte;
                n_left  = left_dec;
                n_idx   = '0;
                n_acc   = '0;
                n_phase = (left_dec != 8'd0) ? bafe_pkg::PH_DATA : bafe_pkg::PH_LEN;
            end
            bafe_pkg::PH_DATA: begin
                n_acc = acc_new;
                unique case (c_type)
                    bafe_pkg::AD_NAME: begin
                        emit      = 1'b1;
                        res.kind  = bafe_pkg::KIND_NAME;
                        res.value = {56'd0, r_ad_byte};
                    end
                    bafe_pkg::AD_TXPWR: begin
                        if (c_idx == 8'd0) begin
                            emit      = 1'b1;
                            res.kind  = bafe_pkg::KIND_TXPWR;
                            res.value = {56'd0, r_ad_byte};
                        end
                    end
                    bafe_pkg::AD_FLAGS: begin
                        if (c_idx == 8'd0) begin
                            emit      = 1'b1;
                            res.kind  = bafe_pkg::KIND_FLAGS;
                            res.value = {56'd0, r_ad_byte};
                        end
                    end
                    bafe_pkg::AD_APPR: begin
                        if (c_idx == 8'd1) begin
                            emit      = 1'b1;
                            res.kind  = bafe_pkg::KIND_APPR;
                            res.value = acc_new;
                        end
                    end
                    bafe_pkg::AD_U16: begin
                        if (c_idx == 8'd1) begin
                            emit      = 1'b1;
                            res.kind  = bafe_pkg::KIND_U16;
                            res.value = acc_new;
                        end
                    end
                    bafe_pkg::AD_MANUF: begin
                        if (c_idx == 8'd1) begin
                            emit      = 1'b1;
                            res.kind  = bafe_pkg::KIND_MANUF;
                            res.value = acc_new;
                        end
                    end
                    bafe_pkg::AD_U128: begin
                        if (c_idx == 8'd7 || c_idx == 8'd15) begin
                            emit      = 1'b1;
                            res.kind  = bafe_pkg::KIND_U128;
                            res.value = acc_new;
                            res.half  = (c_idx == 8'd15);
                        end
                    end
                    default: begin
                    end
                endcase
                n_idx  = (c_idx == 8'hFF) ? c_idx : c_idx + 8'd1;
                n_left = left_dec;
                if (left_dec == 8'd0) begin
                    n_phase = bafe_pkg::PH_LEN;
                end
            end
        endcase

        if (n_cnt >= i_limit) begin
            done = 1'b1;
        end
        if (done) begin
            n_phase = bafe_pkg::PH_IDLE;
        end
        if (!active) begin
            emit = 1'b0;
            done = 1'b0;
        end
        res.done = done;
    end

    // an item with no word to send never waits on the output side
    assign o_res_valid = r_in_valid && (emit || done);
    assign advance     = r_in_valid && (!(emit || done) || i_res_ready);
    assign o_ready     = !r_in_valid || advance;
    assign o_res       = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_ad_byte <= i_ad_byte;
            r_first   <= i_first_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= bafe_pkg::PH_IDLE;
            r_left  <= '0;
            r_type  <= '0;
            r_idx   <= '0;
            r_acc   <= '0;
            r_cnt   <= '0;
        end else if (advance) begin
            r_phase <= n_phase;
            r_left  <= n_left;
            r_type  <= n_type;
            r_idx   <= n_idx;
            r_acc   <= n_acc;
            r_cnt   <= n_cnt;
        end
    end

endmodule

`default_nettype wire

[sv/bafe_obuf.sv]
// Output register holding one result word until the sink takes it.
`default_nettype none

module bafe_obuf (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire bafe_pkg::t_result i_res,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output bafe_pkg::t_result      o_res
);

    logic              r_valid;
    bafe_pkg::t_result r_res;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_res <= i_res;
        end
    end

endmodule

`default_nettype wire

[sv/bafe_checker.sv]
// Port-level checks on the field extractor's result channel, bound to the top level.
`default_nettype none

module bafe_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_ready,
    input  wire logic [2:0]  i_kind,
    input  wire logic [63:0] i_value,
    input  wire logic        i_half,
    input  wire logic        i_done
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_kind)
            && $stable(i_value) && $stable(i_half) && $stable(i_done))
        else $error("result word changed while stalled");

    a_end_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_kind == bafe_pkg::KIND_END |-> i_done && i_value == 64'd0)
        else $error("end-only word without payload end or with a value");

    a_half_u128: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_half |-> i_kind == bafe_pkg::KIND_U128)
        else $error("half index set on a non-UUID128 word");

    a_byte_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_kind == bafe_pkg::KIND_NAME || i_kind == bafe_pkg::KIND_TXPWR
            || i_kind == bafe_pkg::KIND_FLAGS) |-> i_value[63:8] == 56'd0)
        else $error("single-byte field wider than one byte");

    a_two_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_kind == bafe_pkg::KIND_APPR || i_kind == bafe_pkg::KIND_U16
            || i_kind == bafe_pkg::KIND_MANUF) |-> i_value[63:16] == 48'd0)
        else $error("two-byte field wider than two bytes");

endmodule

bind ble_adv_field_extractor bafe_checker u_bafe_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_field.valid),
    .i_out_ready (o_field.ready),
    .i_kind      (o_field.field_kind),
    .i_value     (o_field.field_value),
    .i_half      (o_field.half_index),
    .i_done      (o_field.payload_done)
);

`default_nettype wire
